FILE: rtl/core/slos_pkg.sv
// shared types and constants for the skip list ordered set
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package slos_pkg;

	// default sizing of the node pool and the list
	localparam int POOL_DEPTH_DEF  = 1024;
	localparam int TOP_LEVEL_DEF   = 16;
	localparam int RANGE_LIMIT_DEF = 64;

	// field widths fixed by the stream format
	localparam int REQ_W     = 3;
	localparam int SCORE_W   = 32;
	localparam int HANDLE_W  = 16;
	localparam int LEVEL_W   = 5;
	localparam int RANK_W    = 11;
	localparam int STATUS_W  = 3;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 72;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FIND     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_GET_RANK = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RANK_OF  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_RANGE    = 3'd5;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUP       = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD       = 3'd4
	} stat_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_RD_X,
		OP_RD_NXT,
		OP_ADV,
		OP_LOC_DOWN,
		OP_LOC_DOWN_END,
		OP_ALLOC,
		OP_INS_NEW,
		OP_RD_UPD,
		OP_WR_NEWLINK,
		OP_WR_UPD_NEW,
		OP_LV_ZERO,
		OP_RD_CAND,
		OP_WR_UPD_RD,
		OP_LV_INC,
		OP_SHRINK,
		OP_REM_PUSH,
		OP_ADV_LINK,
		OP_RANK_ZERO,
		OP_RANGE_INIT,
		OP_CNT_STEP,
		OP_SET_MORE,
		OP_OUT_ERR,
		OP_OUT_INS,
		OP_OUT_REM,
		OP_OUT_FIND,
		OP_OUT_RANK,
		OP_OUT_RANGE
	} op_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_ERR,
		S_LOC_RD,
		S_LOC_LINK,
		S_LOC_SC,
		S_LOC_DONE,
		S_INS_NEW,
		S_INS_RD,
		S_INS_W1,
		S_INS_W2,
		S_INS_FIN,
		S_REM_RD,
		S_REM_CHK,
		S_REM_WR,
		S_REM_SHRINK,
		S_REM_FIN,
		S_RK_RD,
		S_RK_CHK,
		S_RK_DONE,
		S_FIND_FIN,
		S_GR_RD,
		S_GR_CHK,
		S_GR_FIN,
		S_RG_C_RD,
		S_RG_C_CHK,
		S_RG_E_RD,
		S_RG_E_OUT
	} state_t;

	// command from controller to datapath
	typedef struct packed {
		op_t   op;
		stat_t code;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic bad_range;
		logic tgt_bad;
		logic link_ge_pool;
		logic link_eq_cand;
		logic lt_key;
		logic lv_zero;
		logic hit;
		logic cand_miss;
		logic free_empty;
		logic ins_lv_last;
		logic rem_lv_last;
		logic top_empty;
		logic rank_eq_tgt;
		logic x_in_range;
		logic k_full;
		logic k_one;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/skip_list_ordered_set.sv
// top level of the skip list ordered set
// depends on slos_pkg, slos_ctrl and slos_datapath
`timescale 1ns / 1ps

// Usage:
// One request word enters on the s_ channel (s_tuser holds the request code) and
// one or more result words leave on the m_ channel (m_tuser holds the status,
// m_tlast marks the final word of a request). A request is taken only while the
// sequencer is idle; it then walks the list through the node memories, one
// registered read per step. Locating a score follows the links of each list
// level and steps down a level when the next score is not below the key; an
// insert writes the links of each node level, a remove visits every list
// level; rank walks pass the entries at level 0 one by one; a range counts
// the entries in range, then sends one word per entry counted. Find, rank-of
// and range requests add the level 0 walk to the locate step, and a get-rank
// request walks level 0 alone. One request is in flight at a time.
// Results sit in a single output register, so the block goes on working on the
// next request while the receiver stalls, and waits only when a new word would
// overwrite one not yet taken. Reset acts at once: the list is empty, level 1,
// with every node free; no memory clearing pass is needed.

module skip_list_ordered_set #(
	parameter int POOL_DEPTH  = slos_pkg::POOL_DEPTH_DEF,
	parameter int TOP_LEVEL   = slos_pkg::TOP_LEVEL_DEF,
	parameter int RANGE_LIMIT = slos_pkg::RANGE_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_score, score_high, member_handle, node_level, target_rank, from bit 0
	input  logic [slos_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [slos_pkg::REQ_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_member, out_score, out_rank, set_length, truncated, zero pad, from bit 0
	output logic [slos_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [slos_pkg::STATUS_W-1:0]   m_tuser,
	output logic                            m_tlast
);
	import slos_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	slos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memories and walk registers
	slos_datapath #(
		.POOL_DEPTH  (POOL_DEPTH),
		.TOP_LEVEL   (TOP_LEVEL),
		.RANGE_LIMIT (RANGE_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.in_req   (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/core/slos_ctrl.sv
// request sequencer of the skip list ordered set
// depends on slos_pkg; drives the datapath through cmd_t and reads sts_t
`timescale 1ns / 1ps

module slos_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  slos_pkg::sts_t sts,
	output slos_pkg::cmd_t cmd
);
	import slos_pkg::*;

	state_t state_q, state_d;
	stat_t  err_q, err_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (sts.req > REQ_RANGE) begin
					err_d = ST_BAD; state_d = S_ERR;
				end else if (sts.req == REQ_GET_RANK) begin
					if (sts.tgt_bad) begin
						err_d = ST_NOT_FOUND; state_d = S_ERR;
					end else state_d = S_GR_RD;
				end else if (sts.req == REQ_RANGE && sts.bad_range) begin
					err_d = ST_BAD; state_d = S_ERR;
				end else state_d = S_LOC_RD;
			end
			S_ERR: if (sts.out_free) state_d = S_IDLE;
			S_LOC_RD: state_d = S_LOC_LINK;
			S_LOC_LINK: begin
				if (sts.link_ge_pool) state_d = sts.lv_zero ? S_LOC_DONE : S_LOC_RD;
				else state_d = S_LOC_SC;
			end
			S_LOC_SC: begin
				if (sts.lt_key) state_d = S_LOC_RD;
				else state_d = sts.lv_zero ? S_LOC_DONE : S_LOC_RD;
			end
			S_LOC_DONE: begin
				case (sts.req)
					REQ_INSERT: begin
						if (sts.free_empty) begin
							err_d = ST_FULL; state_d = S_ERR;
						end else if (sts.hit) begin
							err_d = ST_DUP; state_d = S_ERR;
						end else state_d = S_INS_NEW;
					end
					REQ_REMOVE: begin
						if (!sts.hit) begin
							err_d = ST_NOT_FOUND; state_d = S_ERR;
						end else state_d = S_REM_RD;
					end
					REQ_FIND, REQ_RANK_OF: begin
						if (!sts.hit) begin
							err_d = ST_NOT_FOUND; state_d = S_ERR;
						end else state_d = S_RK_RD;
					end
					REQ_RANGE: begin
						if (sts.cand_miss) begin
							err_d = ST_NOT_FOUND; state_d = S_ERR;
						end else state_d = S_RK_RD;
					end
					default: begin
						err_d = ST_BAD; state_d = S_ERR;
					end
				endcase
			end
			S_INS_NEW: state_d = S_INS_RD;
			S_INS_RD:  state_d = S_INS_W1;
			S_INS_W1:  state_d = S_INS_W2;
			S_INS_W2:  state_d = sts.ins_lv_last ? S_INS_FIN : S_INS_RD;
			S_INS_FIN: if (sts.out_free) state_d = S_IDLE;
			S_REM_RD:  state_d = S_REM_CHK;
			S_REM_CHK: begin
				if (sts.link_eq_cand) state_d = S_REM_WR;
				else state_d = sts.rem_lv_last ? S_REM_SHRINK : S_REM_RD;
			end
			S_REM_WR: state_d = sts.rem_lv_last ? S_REM_SHRINK : S_REM_RD;
			S_REM_SHRINK: if (!sts.top_empty) state_d = S_REM_FIN;
			S_REM_FIN: if (sts.out_free) state_d = S_IDLE;
			S_RK_RD: state_d = S_RK_CHK;
			S_RK_CHK: begin
				if (sts.link_eq_cand || sts.link_ge_pool) state_d = S_RK_DONE;
				else state_d = S_RK_RD;
			end
			S_RK_DONE: state_d = (sts.req == REQ_RANGE) ? S_RG_C_RD : S_FIND_FIN;
			S_FIND_FIN: if (sts.out_free) state_d = S_IDLE;
			S_GR_RD: state_d = S_GR_CHK;
			S_GR_CHK: begin
				if (sts.link_ge_pool) begin
					err_d = ST_NOT_FOUND; state_d = S_ERR;
				end else if (sts.rank_eq_tgt) state_d = S_GR_FIN;
				else state_d = S_GR_RD;
			end
			S_GR_FIN: if (sts.out_free) state_d = S_IDLE;
			S_RG_C_RD: state_d = S_RG_C_CHK;
			S_RG_C_CHK: begin
				if (!sts.k_full && sts.x_in_range) state_d = S_RG_C_RD;
				else state_d = S_RG_E_RD;
			end
			S_RG_E_RD: state_d = S_RG_E_OUT;
			S_RG_E_OUT: if (sts.out_free) state_d = sts.k_one ? S_IDLE : S_RG_E_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op   = OP_NOP;
		cmd.code = err_q;
		s_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: if (s_tvalid) cmd.op = OP_CAPTURE;
			S_DISPATCH: begin
				if (sts.req == REQ_GET_RANK && !sts.tgt_bad) cmd.op = OP_LV_ZERO;
			end
			S_ERR: if (sts.out_free) cmd.op = OP_OUT_ERR;
			S_LOC_RD: cmd.op = OP_RD_X;
			S_LOC_LINK: cmd.op = sts.link_ge_pool ? OP_LOC_DOWN_END : OP_RD_NXT;
			S_LOC_SC: cmd.op = sts.lt_key ? OP_ADV : OP_LOC_DOWN;
			S_LOC_DONE: begin
				case (sts.req)
					REQ_INSERT: if (!sts.free_empty && !sts.hit) cmd.op = OP_ALLOC;
					REQ_REMOVE, REQ_FIND, REQ_RANK_OF: if (sts.hit) cmd.op = OP_LV_ZERO;
					REQ_RANGE: if (!sts.cand_miss) cmd.op = OP_LV_ZERO;
					default: cmd.op = OP_NOP;
				endcase
			end
			S_INS_NEW: cmd.op = OP_INS_NEW;
			S_INS_RD:  cmd.op = OP_RD_UPD;
			S_INS_W1:  cmd.op = OP_WR_NEWLINK;
			S_INS_W2:  cmd.op = OP_WR_UPD_NEW;
			S_INS_FIN: if (sts.out_free) cmd.op = OP_OUT_INS;
			S_REM_RD:  cmd.op = OP_RD_UPD;
			S_REM_CHK: cmd.op = sts.link_eq_cand ? OP_RD_CAND : OP_LV_INC;
			S_REM_WR:  cmd.op = OP_WR_UPD_RD;
			S_REM_SHRINK: cmd.op = sts.top_empty ? OP_SHRINK : OP_REM_PUSH;
			S_REM_FIN: if (sts.out_free) cmd.op = OP_OUT_REM;
			S_RK_RD:   cmd.op = OP_RD_X;
			S_RK_CHK: begin
				if (sts.link_eq_cand) cmd.op = OP_NOP;
				else if (sts.link_ge_pool) cmd.op = OP_RANK_ZERO;
				else cmd.op = OP_ADV_LINK;
			end
			S_RK_DONE: cmd.op = (sts.req == REQ_RANGE) ? OP_RANGE_INIT : OP_RD_CAND;
			S_FIND_FIN: if (sts.out_free) cmd.op = OP_OUT_FIND;
			S_GR_RD:   cmd.op = OP_RD_X;
			S_GR_CHK: begin
				if (sts.link_ge_pool) cmd.op = OP_NOP;
				else if (sts.rank_eq_tgt) cmd.op = OP_RD_NXT;
				else cmd.op = OP_ADV_LINK;
			end
			S_GR_FIN: if (sts.out_free) cmd.op = OP_OUT_RANK;
			S_RG_C_RD: cmd.op = OP_RD_X;
			S_RG_C_CHK: begin
				if (!sts.k_full && sts.x_in_range) cmd.op = OP_CNT_STEP;
				else cmd.op = OP_SET_MORE;
			end
			S_RG_E_RD: cmd.op = OP_RD_X;
			S_RG_E_OUT: if (sts.out_free) cmd.op = OP_OUT_RANGE;
			default: cmd.op = OP_NOP;
		endcase
	end

endmodule

FILE: rtl/core/slos_datapath.sv
// node memories, free-node bookkeeping, walk registers and output register
// depends on slos_pkg; steered by slos_ctrl through cmd_t
`timescale 1ns / 1ps

module slos_datapath #(
	parameter int POOL_DEPTH  = slos_pkg::POOL_DEPTH_DEF,
	parameter int TOP_LEVEL   = slos_pkg::TOP_LEVEL_DEF,
	parameter int RANGE_LIMIT = slos_pkg::RANGE_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [slos_pkg::IN_DATA_W-1:0]  in_data,
	input  logic [slos_pkg::REQ_W-1:0]      in_req,
	input  slos_pkg::cmd_t                  cmd,
	output slos_pkg::sts_t                  sts,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [slos_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [slos_pkg::STATUS_W-1:0]   m_tuser,
	output logic                            m_tlast
);
	import slos_pkg::*;

	localparam int IW     = $clog2(POOL_DEPTH + 2);
	localparam int AW     = $clog2(POOL_DEPTH);
	localparam int LVW    = (TOP_LEVEL > 1) ? $clog2(TOP_LEVEL) : 1;
	localparam int LVLW   = $clog2(TOP_LEVEL + 1);
	localparam int CW     = $clog2(POOL_DEPTH + 1);
	localparam int LDEPTH = POOL_DEPTH * TOP_LEVEL;
	localparam int LAW    = $clog2(LDEPTH);
	localparam int KW     = $clog2(RANGE_LIMIT + 1);
	localparam logic [IW-1:0] HEAD_N = IW'(POOL_DEPTH);
	localparam logic [IW-1:0] END_N  = IW'(POOL_DEPTH + 1);

	// node memories
	logic signed [SCORE_W-1:0]  score_mem  [POOL_DEPTH];
	logic        [HANDLE_W-1:0] member_mem [POOL_DEPTH];
	logic        [IW-1:0]       link_mem   [LDEPTH];
	logic        [AW-1:0]       stack_mem  [POOL_DEPTH];

	// persistent list state
	logic [IW-1:0]   head_q [TOP_LEVEL];
	logic [LVLW-1:0] list_level_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   fresh_q;
	logic [CW-1:0]   rstk_q;

	// request and walk registers
	logic [REQ_W-1:0]          req_q;
	logic signed [SCORE_W-1:0] key_q, high_q;
	logic [HANDLE_W-1:0]       hnd_q;
	logic [LVLW-1:0]           lvl_q;
	logic [RANK_W-1:0]         tgt_q;
	logic [IW-1:0]             x_q, nxt_q, cand_q, new_q;
	logic signed [SCORE_W-1:0] cand_sc_q;
	logic [LVW-1:0]            lv_q;
	logic [IW-1:0]             upd_q [TOP_LEVEL];
	logic [CW-1:0]             rank_q;
	logic [KW-1:0]             k_q;
	logic                      more_q, src_q;

	// read data
	logic signed [SCORE_W-1:0] rd_score_q;
	logic [HANDLE_W-1:0]       rd_member_q;
	logic [IW-1:0]             rd_link_q;
	logic [AW-1:0]             rd_stack_q;

	// output register
	logic                      out_valid_q;
	stat_t                     out_st_q;
	logic [HANDLE_W-1:0]       out_mem_q;
	logic [SCORE_W-1:0]        out_sc_q;
	logic [RANK_W-1:0]         out_rk_q;
	logic [RANK_W-1:0]         out_len_q;
	logic                      out_tr_q, out_last_q;

	// unpacked input fields
	logic signed [SCORE_W-1:0] f_key, f_high;
	logic [HANDLE_W-1:0]       f_hnd;
	logic [LEVEL_W-1:0]        f_lvl;
	logic [RANK_W-1:0]         f_tgt;
	logic [LVLW-1:0]           lvl_clamp;

	logic [IW-1:0]   rd_node, upd_sel, new_idx;
	logic            rd_en, lk_we, out_ld, out_free;
	logic [LAW-1:0]  lk_waddr;
	logic [IW-1:0]   lk_wdata;
	logic [LVLW-1:0] lv_p1;

	function automatic logic [LAW-1:0] link_addr(input logic [IW-1:0] node,
		input logic [LVW-1:0] lv);
		return LAW'(node[AW-1:0]) * LAW'(TOP_LEVEL) + LAW'(lv);
	endfunction

	// input unpacking and level clamp
	assign f_key  = in_data[31:0];
	assign f_high = in_data[63:32];
	assign f_hnd  = in_data[79:64];
	assign f_lvl  = in_data[84:80];
	assign f_tgt  = in_data[95:85];

	always_comb begin
		if (f_lvl == '0) lvl_clamp = LVLW'(1);
		else if (f_lvl > LEVEL_W'(TOP_LEVEL)) lvl_clamp = LVLW'(TOP_LEVEL);
		else lvl_clamp = LVLW'(f_lvl);
	end

	// read address and link write steering
	assign upd_sel  = upd_q[lv_q];
	assign new_idx  = src_q ? IW'(rd_stack_q) : (HEAD_N - IW'(fresh_q));
	assign out_free = !out_valid_q || m_tready;
	assign lv_p1    = LVLW'(lv_q) + LVLW'(1);

	always_comb begin
		rd_en   = 1'b1;
		rd_node = x_q;
		case (cmd.op)
			OP_RD_X:      rd_node = x_q;
			OP_RD_NXT:    rd_node = rd_link_q;
			OP_RD_UPD:    rd_node = upd_sel;
			OP_RD_CAND:   rd_node = cand_q;
			OP_REM_PUSH:  rd_node = cand_q;
			default:      rd_en = 1'b0;
		endcase
	end

	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = link_addr(upd_sel, lv_q);
		lk_wdata = rd_link_q;
		case (cmd.op)
			OP_WR_NEWLINK: begin
				lk_we    = 1'b1;
				lk_waddr = link_addr(new_q, lv_q);
			end
			OP_WR_UPD_NEW: begin
				lk_we    = (upd_sel != HEAD_N);
				lk_wdata = new_q;
			end
			OP_WR_UPD_RD: lk_we = (upd_sel != HEAD_N);
			default: lk_we = 1'b0;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.op == OP_INS_NEW) begin
			score_mem[new_idx[AW-1:0]]  <= key_q;
			member_mem[new_idx[AW-1:0]] <= hnd_q;
		end
		if (lk_we) link_mem[lk_waddr] <= lk_wdata;
		if (cmd.op == OP_REM_PUSH) stack_mem[rstk_q[AW-1:0]] <= cand_q[AW-1:0];
		if (cmd.op == OP_ALLOC) rd_stack_q <= stack_mem[AW'(rstk_q - CW'(1))];
		if (rd_en) begin
			rd_score_q  <= score_mem[rd_node[AW-1:0]];
			rd_member_q <= member_mem[rd_node[AW-1:0]];
			rd_link_q   <= (rd_node == HEAD_N) ? head_q[lv_q]
				: link_mem[link_addr(rd_node, lv_q)];
		end
	end

	// list state, free-node counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_LEVEL; i++) head_q[i] <= END_N;
			list_level_q <= LVLW'(1);
			count_q      <= '0;
			fresh_q      <= CW'(POOL_DEPTH);
			rstk_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ld) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ALLOC: if (rstk_q != '0) rstk_q <= rstk_q - CW'(1);
				OP_INS_NEW: if (!src_q) fresh_q <= fresh_q - CW'(1);
				OP_WR_UPD_NEW: if (upd_sel == HEAD_N) head_q[lv_q] <= new_q;
				OP_WR_UPD_RD: if (upd_sel == HEAD_N) head_q[lv_q] <= rd_link_q;
				OP_SHRINK: list_level_q <= list_level_q - LVLW'(1);
				OP_REM_PUSH: rstk_q <= rstk_q + CW'(1);
				OP_OUT_INS: begin
					count_q <= count_q + CW'(1);
					if (lvl_q > list_level_q) list_level_q <= lvl_q;
				end
				OP_OUT_REM: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				req_q  <= in_req;
				key_q  <= f_key;
				high_q <= f_high;
				hnd_q  <= f_hnd;
				lvl_q  <= lvl_clamp;
				tgt_q  <= f_tgt;
				x_q    <= HEAD_N;
				lv_q   <= LVW'(list_level_q - LVLW'(1));
				for (int i = 0; i < TOP_LEVEL; i++) upd_q[i] <= HEAD_N;
			end
			OP_RD_NXT: nxt_q <= rd_link_q;
			OP_ADV: x_q <= nxt_q;
			OP_LOC_DOWN: begin
				upd_q[lv_q] <= x_q;
				if (lv_q == '0) begin
					cand_q    <= nxt_q;
					cand_sc_q <= rd_score_q;
				end else lv_q <= lv_q - LVW'(1);
			end
			OP_LOC_DOWN_END: begin
				upd_q[lv_q] <= x_q;
				if (lv_q == '0) cand_q <= END_N;
				else lv_q <= lv_q - LVW'(1);
			end
			OP_ALLOC: src_q <= (rstk_q != '0);
			OP_INS_NEW: begin
				new_q <= new_idx;
				lv_q  <= '0;
			end
			OP_WR_UPD_NEW, OP_WR_UPD_RD, OP_LV_INC: lv_q <= lv_q + LVW'(1);
			OP_LV_ZERO: begin
				lv_q   <= '0;
				x_q    <= HEAD_N;
				rank_q <= CW'(1);
			end
			OP_ADV_LINK: begin
				x_q    <= rd_link_q;
				rank_q <= rank_q + CW'(1);
			end
			OP_RANK_ZERO: rank_q <= '0;
			OP_RANGE_INIT: begin
				x_q <= cand_q;
				k_q <= '0;
			end
			OP_CNT_STEP: begin
				x_q <= rd_link_q;
				k_q <= k_q + KW'(1);
			end
			OP_SET_MORE: begin
				x_q    <= cand_q;
				more_q <= sts.x_in_range;
			end
			OP_OUT_RANGE: begin
				x_q    <= rd_link_q;
				k_q    <= k_q - KW'(1);
				rank_q <= rank_q + CW'(1);
			end
			default: ;
		endcase
	end

	// result word
	always_comb begin
		out_ld = 1'b1;
		case (cmd.op)
			OP_OUT_ERR, OP_OUT_INS, OP_OUT_REM, OP_OUT_FIND, OP_OUT_RANK, OP_OUT_RANGE:
				out_ld = 1'b1;
			default: out_ld = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			case (cmd.op)
				OP_OUT_ERR: begin
					out_st_q   <= cmd.code;
					out_mem_q  <= '0;
					out_sc_q   <= '0;
					out_rk_q   <= '0;
					out_len_q  <= RANK_W'(count_q);
					out_tr_q   <= 1'b0;
					out_last_q <= 1'b1;
				end
				OP_OUT_INS: begin
					out_st_q   <= ST_OK;
					out_mem_q  <= hnd_q;
					out_sc_q   <= key_q;
					out_rk_q   <= '0;
					out_len_q  <= RANK_W'(count_q + CW'(1));
					out_tr_q   <= 1'b0;
					out_last_q <= 1'b1;
				end
				OP_OUT_REM: begin
					out_st_q   <= ST_OK;
					out_mem_q  <= rd_member_q;
					out_sc_q   <= key_q;
					out_rk_q   <= '0;
					out_len_q  <= RANK_W'(count_q - CW'(1));
					out_tr_q   <= 1'b0;
					out_last_q <= 1'b1;
				end
				OP_OUT_FIND: begin
					out_st_q   <= ST_OK;
					out_mem_q  <= rd_member_q;
					out_sc_q   <= key_q;
					out_rk_q   <= RANK_W'(rank_q);
					out_len_q  <= RANK_W'(count_q);
					out_tr_q   <= 1'b0;
					out_last_q <= 1'b1;
				end
				OP_OUT_RANK: begin
					out_st_q   <= ST_OK;
					out_mem_q  <= rd_member_q;
					out_sc_q   <= rd_score_q;
					out_rk_q   <= tgt_q;
					out_len_q  <= RANK_W'(count_q);
					out_tr_q   <= 1'b0;
					out_last_q <= 1'b1;
				end
				default: begin
					out_st_q   <= ST_OK;
					out_mem_q  <= rd_member_q;
					out_sc_q   <= rd_score_q;
					out_rk_q   <= RANK_W'(rank_q);
					out_len_q  <= RANK_W'(count_q);
					out_tr_q   <= more_q;
					out_last_q <= (k_q == KW'(1));
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_tr_q, out_len_q, out_rk_q, out_sc_q, out_mem_q};

	// status to the controller
	always_comb begin
		sts.req          = req_q;
		sts.bad_range    = key_q > high_q;
		sts.tgt_bad      = (tgt_q == '0) || (CW'(0) + tgt_q > count_q);
		sts.link_ge_pool = rd_link_q >= HEAD_N;
		sts.link_eq_cand = rd_link_q == cand_q;
		sts.lt_key       = rd_score_q < key_q;
		sts.lv_zero      = lv_q == '0;
		sts.hit          = (cand_q < HEAD_N) && (cand_sc_q == key_q);
		sts.cand_miss    = (cand_q >= HEAD_N) || (cand_sc_q > high_q);
		sts.free_empty   = (fresh_q == '0) && (rstk_q == '0);
		sts.ins_lv_last  = lv_p1 == lvl_q;
		sts.rem_lv_last  = lv_p1 == list_level_q;
		sts.top_empty    = (list_level_q > LVLW'(1)) &&
			(head_q[LVW'(list_level_q - LVLW'(1))] == END_N);
		sts.rank_eq_tgt  = rank_q == CW'(tgt_q);
		sts.x_in_range   = (x_q < HEAD_N) && (rd_score_q <= high_q);
		sts.k_full       = k_q == KW'(RANGE_LIMIT);
		sts.k_one        = k_q == KW'(1);
		sts.out_free     = out_free;
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(POOL_DEPTH))
		else $error("entry count beyond pool depth");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		list_level_q >= LVLW'(1) && list_level_q <= LVLW'(TOP_LEVEL))
		else $error("list level out of bounds");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> out_free)
		else $error("result word overwritten while stalled");

	a_full_no_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ALLOC) |-> !sts.free_empty)
		else $error("node allocated from an empty pool");

endmodule

FILE: tb/tb_skip_list_ordered_set.sv
// self-checking testbench for the skip list ordered set
// depends on slos_pkg and skip_list_ordered_set; an ordered-queue predictor checks each word
`timescale 1ns / 1ps

module tb_skip_list_ordered_set;
	import slos_pkg::*;

	localparam int POOL = 1024;
	localparam int RLIM = 64;
	localparam int IDLE_LIMIT = 40000;
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
	localparam int SMIN = 32'sh80000000;
	localparam int SMAX = 32'sh7fffffff;

	typedef struct {
		logic [REQ_W-1:0] req;
		int               key;
		int               hi;
		logic [15:0]      mem;
		logic [4:0]       lvl;
		logic [10:0]      rank;
		bit               typed;
		stat_t            st;
	} req_word_t;

	typedef struct {
		stat_t       st;
		logic [15:0] mem;
		logic [31:0] score;
		logic [10:0] rank;
		logic [10:0] len;
		logic        trunc;
		logic        lst;
	} result_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0] s_tuser = '0;
	logic m_tvalid, m_tready = 0, m_tlast;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// ordered contents of the set, ascending by score
	int          set_scores[$];
	logic [15:0] set_members[$];
	result_t     pending_results[$];
	req_word_t   directed_rows[$];
	int          fail_count = 0;
	int          burst_left = 0;
	int          hold_cnt = 0;
	bit          hold_go = 0;
	int          idle_cycles = 0;

	skip_list_ordered_set uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// queue one result word
	task automatic push_result(stat_t st, logic [15:0] mem, int score, int rank, bit trunc,
			bit lst);
		result_t r;
		r.st = st;
		r.mem = (st == ST_OK) ? mem : '0;
		r.score = (st == ST_OK) ? score : '0;
		r.rank = (st == ST_OK) ? rank[10:0] : '0;
		r.len = 11'(set_scores.size());
		r.trunc = trunc;
		r.lst = lst;
		pending_results.push_back(r);
	endtask

	// index of the first entry with score >= key, or size when none
	function automatic int lower_index(int key);
		int i;
		for (i = 0; i < set_scores.size(); i++)
			if (set_scores[i] >= key) return i;
		return set_scores.size();
	endfunction

	// apply one request to the ordered set and queue its results
	task automatic ordered_set_apply(req_word_t w);
		int idx, n, k, j;
		bit hit;
		idx = lower_index(w.key);
		hit = idx < set_scores.size() && set_scores[idx] == w.key;
		case (w.req)
			REQ_INSERT: begin
				if (set_scores.size() == POOL) push_result(ST_FULL, 0, 0, 0, 0, 1);
				else if (hit) push_result(ST_DUP, 0, 0, 0, 0, 1);
				else begin
					set_scores.insert(idx, w.key);
					set_members.insert(idx, w.mem);
					push_result(ST_OK, w.mem, w.key, 0, 0, 1);
				end
			end
			REQ_REMOVE: begin
				if (!hit) push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1);
				else begin
					n = set_members[idx];
					set_scores.delete(idx);
					set_members.delete(idx);
					push_result(ST_OK, n[15:0], w.key, 0, 0, 1);
				end
			end
			REQ_FIND, REQ_RANK_OF: begin
				if (!hit) push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1);
				else push_result(ST_OK, set_members[idx], w.key, idx + 1, 0, 1);
			end
			REQ_GET_RANK: begin
				if (w.rank == 0 || w.rank > set_scores.size())
					push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1);
				else push_result(ST_OK, set_members[w.rank-1], set_scores[w.rank-1],
						w.rank, 0, 1);
			end
			REQ_RANGE: begin
				if (w.key > w.hi) push_result(ST_BAD, 0, 0, 0, 0, 1);
				else if (idx >= set_scores.size() || set_scores[idx] > w.hi)
					push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1);
				else begin
					n = 0;
					for (j = idx; j < set_scores.size() && set_scores[j] <= w.hi; j++) n++;
					k = (n > RLIM) ? RLIM : n;
					for (j = 0; j < k; j++)
						push_result(ST_OK, set_members[idx+j], set_scores[idx+j], idx + j + 1,
								n > RLIM, j == k - 1);
				end
			end
			default: push_result(ST_BAD, 0, 0, 0, 0, 1);
		endcase
	endtask

	// offer one request word, predict on acceptance, then maybe open a gap
	task automatic send_word(req_word_t w);
		int first, g;
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser <= w.req;
		s_tdata <= {w.rank, w.lvl, w.mem, w.hi, w.key};
		do @(posedge clk); while (!s_tready);
		first = pending_results.size();
		ordered_set_apply(w);
		if (w.typed) pending_results[first].st = w.st;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (g > 0) begin
				@(negedge clk);
				s_tvalid <= 0;
				repeat (g - 1) @(negedge clk);
			end
		end
	endtask

	task automatic add_row(logic [REQ_W-1:0] req, int key, int hi, logic [15:0] mem,
			logic [4:0] lvl, logic [10:0] rank, bit typed, stat_t st);
		req_word_t w;
		w.req = req; w.key = key; w.hi = hi; w.mem = mem; w.lvl = lvl; w.rank = rank;
		w.typed = typed; w.st = st;
		directed_rows.push_back(w);
	endtask

	function automatic logic [4:0] pick_level();
		logic [4:0] l;
		if ($urandom_range(0, 15) == 0) return 5'($urandom_range(0, 31));
		l = 5'd1;
		while (l < 16 && $urandom_range(0, 1)) l++;
		return l;
	endfunction

	// keys from a coarse grid so hits are common, spread over both signs
	function automatic int pick_key();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return ($urandom_range(0, 80) - 40) * 52000000;
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int p;
		p = $urandom_range(0, 99);
		w.req = (p < 35) ? REQ_INSERT : (p < 55) ? REQ_REMOVE : (p < 65) ? REQ_FIND :
			(p < 75) ? REQ_GET_RANK : (p < 85) ? REQ_RANK_OF : (p < 97) ? REQ_RANGE :
			(p < 98) ? REQ_SPARE_LO : REQ_SPARE_HI;
		w.key = pick_key();
		if ($urandom_range(0, 4) == 0) w.hi = $urandom;
		else if ($urandom_range(0, 5) == 0) w.hi = w.key - $urandom_range(1, 100000000);
		else w.hi = w.key + $urandom_range(0, 400000000);
		if (w.req == REQ_RANGE && w.key > 32'sh60000000 && w.hi < w.key &&
				$urandom_range(0, 1)) w.hi = SMAX;
		w.mem = 16'($urandom);
		w.lvl = pick_level();
		w.rank = ($urandom_range(0, 7) == 0) ? 11'($urandom) :
			11'($urandom_range(0, set_scores.size() + 2));
		w.typed = 0;
		w.st = ST_OK;
		return w;
	endfunction

	// receiver: stall pattern per segment, plus a long hold on request
	int rx_mode = 0, rx_seg = 0;
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_cnt = 400;
		end
		if (rx_seg == 0) begin
			rx_seg = $urandom_range(16, 96);
			rx_mode = $urandom_range(0, 3);
		end
		rx_seg--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 0;
		end else
			case (rx_mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
	end

	// result checker
	always @(posedge clk) begin
		result_t e;
		logic [OUT_DATA_W-1:0] exp_data;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word tuser=%0d tdata=%h tlast=%b", $time, m_tuser,
					m_tdata, m_tlast);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				exp_data = {1'b0, e.trunc, e.len, e.rank, e.score, e.mem};
				if (m_tuser !== e.st || m_tdata !== exp_data || m_tlast !== e.lst) begin
					$display("%0t: mismatch expected st=%0d data=%h last=%b actual st=%0d data=%h last=%b",
						$time, e.st, exp_data, e.lst, m_tuser, m_tdata, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL skip_list_ordered_set");
			$finish;
		end
	end

	initial begin
		int i;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed rows: empty set, extremes, duplicates, ranks and ranges
		add_row(REQ_FIND, 0, 0, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_GET_RANK, 0, 0, 0, 1, 1, 1, ST_NOT_FOUND);
		add_row(REQ_RANGE, SMIN, SMAX, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_RANGE, 5, 4, 0, 1, 0, 1, ST_BAD);
		add_row(REQ_SPARE_LO, 0, 0, 0, 1, 0, 1, ST_BAD);
		add_row(REQ_SPARE_HI, -1, -1, 16'hffff, 5'h1f, 11'h7ff, 1, ST_BAD);
		add_row(REQ_REMOVE, 5, 0, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_INSERT, SMIN, 0, 16'h0000, 0, 0, 1, ST_OK);
		add_row(REQ_INSERT, SMAX, 0, 16'hffff, 5'h1f, 0, 1, ST_OK);
		add_row(REQ_INSERT, 0, 0, 16'h1234, 16, 0, 1, ST_OK);
		add_row(REQ_INSERT, 0, 0, 16'h4321, 3, 0, 1, ST_DUP);
		add_row(REQ_INSERT, -1, 0, 16'h00aa, 3, 0, 0, ST_OK);
		add_row(REQ_FIND, SMIN, 0, 0, 1, 0, 0, ST_OK);
		add_row(REQ_RANK_OF, SMAX, 0, 0, 1, 0, 0, ST_OK);
		add_row(REQ_GET_RANK, 0, 0, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_GET_RANK, 0, 0, 0, 1, 4, 0, ST_OK);
		add_row(REQ_GET_RANK, 0, 0, 0, 1, 11'h7ff, 1, ST_NOT_FOUND);
		add_row(REQ_RANGE, SMIN, SMAX, 0, 1, 0, 0, ST_OK);
		add_row(REQ_RANGE, -1, -1, 0, 1, 0, 0, ST_OK);
		add_row(REQ_RANGE, 1, 1000, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_REMOVE, 0, 0, 0, 1, 0, 0, ST_OK);
		add_row(REQ_REMOVE, SMAX, 0, 0, 1, 0, 0, ST_OK);
		add_row(REQ_FIND, 0, 0, 0, 1, 0, 1, ST_NOT_FOUND);
		add_row(REQ_RANK_OF, 12345, 0, 0, 1, 0, 1, ST_NOT_FOUND);
		foreach (directed_rows[i]) send_word(directed_rows[i]);

		// random mix with a long receiver hold and a full drain midway
		for (i = 0; i < 440; i++) begin
			if (i == 150) hold_go = 1;
			if (i == 300) begin
				@(negedge clk) s_tvalid <= 0;
				wait (pending_results.size() == 0);
			end
			send_word(random_word());
		end

		@(negedge clk) s_tvalid <= 0;
		wait (pending_results.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("PASS skip_list_ordered_set");
		else $display("FAIL skip_list_ordered_set");
		$finish;
	end

endmodule
